>>> src/emgfe_pkg.sv
// Shared types and constants of the EMG window feature extractor.
// No dependencies; used by every module of the block.
`default_nettype none
package emgfe_pkg;

  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CH_W       = 2;
  localparam int unsigned KCNT_W     = 7;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned IN_W       = CHANNELS * SAMPLE_W;
  localparam int unsigned OUT_W      = 40;
  localparam int unsigned WINDOW_LEN_DEF = 50;
  localparam logic [STEP_W-1:0] STEP_RESET = 7'd50;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_WINDOW_STEP = 3'd0;

  typedef enum logic [1:0] {
    DIV_AVG = 2'd0,
    DIV_MAV = 2'd1,
    DIV_WL  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic              wr;
    logic              rd_en;
    logic [KCNT_W-1:0] rd_k;
    logic              dev_pass;
    logic              clr;
    logic              div_start;
    div_sel_e          div_sel;
    logic [CH_W-1:0]   ch;
    logic              emit;
    logic              advance;
  } dp_cmd_t;

  typedef struct packed {
    logic trigger;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> src/emg_window_feature_extractor_unit.sv
// Top level of the EMG window feature extractor: stream ports, APB register, and
// the controller and datapath. Depends on emgfe_pkg, emgfe_ctrl and emgfe_datapath.
//
// Each request on the input stream carries one sample of each of the four channels
// and is written into a 64-entry ring. A request that does not complete a window is
// taken at once, and the input stays ready for the next one. When a request
// completes a window of WINDOW_LEN samples, the input stalls while each channel in
// turn is analysed: one pass over the ring sums the window, a division by the window
// length, done as a reciprocal multiplication in a start state and a result state,
// gives the rounded mean, a second pass accumulates the absolute deviation,
// neighbour differences, zero crossings and slope turns, two more divisions round
// the averaged features, and a last state hands the result to the output register,
// waiting while the previous result still waits for the receiver. A completed
// window thus holds the input until all four channels are done; the ring's single
// read port sets this.
// Results leave through an output register, one request per channel with tlast on
// channel 3; the ring is undefined until written and needs no clearing after reset.
`default_nettype none
module emg_window_feature_extractor_unit #(
  parameter int unsigned WINDOW_LEN = emgfe_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // sample_ch0 [11:0], sample_ch1 [23:12], sample_ch2 [35:24], sample_ch3 [47:36]
  input  wire logic [emgfe_pkg::IN_W-1:0]   s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // channel [1:0], mean_abs_value [13:2], zero_crossings [19:14],
  // wave_length [31:20], turns [37:32], zero padding [39:38]
  output logic [emgfe_pkg::OUT_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic                              m_axis_tlast,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [emgfe_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import emgfe_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [STEP_W-1:0] step_q;

  // The window step register; the datapath takes it modulo the ring depth.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_WINDOW_STEP) begin
      step_q <= pwdata[STEP_W-1:0];
    end
  end

  assign prdata = (paddr == REG_WINDOW_STEP) ? 32'(step_q) : '0;

  emgfe_ctrl #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  emgfe_datapath #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .sample_i   (s_axis_tdata),
    .step_i     (step_q),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> src/emgfe_div.sv
// Divider by the constant window length, built as a reciprocal multiplication.
// Uses emgfe_pkg only for house conventions; standalone otherwise.
`default_nettype none
module emgfe_div #(
  parameter int unsigned WINDOW_LEN = 50,
  parameter int unsigned ACC_W      = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ACC_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [ACC_W-1:0]      quotient_o
);
  import emgfe_pkg::*;

  // With SHIFT = ACC_W + clog2(WINDOW_LEN) and MULT = ceil(2^SHIFT / WINDOW_LEN),
  // the product shifted right by SHIFT equals the floor quotient for every
  // dividend of ACC_W bits.
  localparam int unsigned     SHIFT  = ACC_W + $clog2(WINDOW_LEN);
  localparam int unsigned     PROD_W = SHIFT + ACC_W;
  localparam longint unsigned RECIP  = ((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [ACC_W:0]  MULT   = (ACC_W+1)'(RECIP);

  logic              done_q;
  logic [ACC_W-1:0]  quot_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(dividend_i) * PROD_W'(MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= prod[SHIFT +: ACC_W];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule
`default_nettype wire

>>> src/emgfe_datapath.sv
// Datapath: sample ring, window pointers, accumulators, divider and output register.
// Depends on emgfe_pkg and emgfe_div.
`default_nettype none
module emgfe_datapath #(
  parameter int unsigned WINDOW_LEN = emgfe_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire emgfe_pkg::dp_cmd_t           cmd_i,
  output emgfe_pkg::dp_status_t             status_o,
  input  wire logic [emgfe_pkg::IN_W-1:0]   sample_i,
  input  wire logic [emgfe_pkg::STEP_W-1:0] step_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [emgfe_pkg::OUT_W-1:0]       out_data_o,
  output logic                              out_last_o
);
  import emgfe_pkg::*;

  localparam int unsigned ACC_W = $clog2(WINDOW_LEN) + SAMPLE_W + 2;
  localparam logic [PTR_W-1:0] END_RESET = PTR_W'(WINDOW_LEN % RING_DEPTH);
  localparam logic [ACC_W-1:0] HALF = ACC_W'(WINDOW_LEN / 2);

  logic [IN_W-1:0]  ring_q [RING_DEPTH];
  logic [IN_W-1:0]  rd_data_q;
  logic [PTR_W-1:0] wr_idx_q, win_start_q, win_end_q, wr_next, step;
  logic             vld_q, dev_q;
  logic [KCNT_W-1:0] k_q;

  logic [ACC_W-1:0] sum_q, abs_q, wl_q;
  logic [CNT_W-1:0] zc_q, tn_q;
  logic [SAMPLE_W-1:0] avg_q, mav_q, wlres_q;
  logic signed [SAMPLE_W+1:0] d1_q, s1_q, d, s;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W:0]   abs_d;
  logic [SAMPLE_W+1:0] abs_s;
  div_sel_e         sel_q;
  logic [ACC_W-1:0] div_in, quot;
  logic             div_done;
  logic             m_valid_q, m_last_q;
  logic [OUT_W-1:0] m_data_q;

  assign step    = step_i[PTR_W-1:0];
  assign wr_next = wr_idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      ring_q[wr_idx_q] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= ring_q[win_start_q + cmd_i.rd_k[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      win_start_q <= '0;
      win_end_q   <= END_RESET;
      vld_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      vld_q <= cmd_i.rd_en;
      if (cmd_i.wr) begin
        wr_idx_q <= wr_next;
        if (wr_next == win_end_q) begin
          win_end_q <= win_end_q + step;
        end
      end
      if (cmd_i.advance) begin
        win_start_q <= win_start_q + step;
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Centred sample, its neighbour slope and their magnitudes.
  assign smp   = rd_data_q[cmd_i.ch*SAMPLE_W +: SAMPLE_W];
  assign d     = $signed({2'b00, smp}) - $signed({2'b00, avg_q});
  assign s     = d - d1_q;
  assign abs_d = d[SAMPLE_W+1] ? (SAMPLE_W+1)'(-d) : (SAMPLE_W+1)'(d);
  assign abs_s = s[SAMPLE_W+1] ? (SAMPLE_W+2)'(-s) : (SAMPLE_W+2)'(s);

  always_ff @(posedge clk_i) begin
    k_q   <= cmd_i.rd_k;
    dev_q <= cmd_i.dev_pass;
    if (cmd_i.clr) begin
      sum_q <= '0;
      abs_q <= '0;
      wl_q  <= '0;
      zc_q  <= '0;
      tn_q  <= '0;
    end else if (vld_q && !dev_q) begin
      sum_q <= sum_q + ACC_W'(smp);
    end else if (vld_q && dev_q) begin
      abs_q <= abs_q + ACC_W'(abs_d);
      d1_q  <= d;
      s1_q  <= s;
      if (k_q != '0) begin
        wl_q <= wl_q + ACC_W'(abs_s);
        if ((d1_q < 0 && d > 0) || (d1_q > 0 && d < 0)) begin
          zc_q <= zc_q + 1'b1;
        end
        if (k_q != KCNT_W'(1) && ((s1_q < 0 && s > 0) || (s1_q > 0 && s < 0))) begin
          tn_q <= tn_q + 1'b1;
        end
      end
    end
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      case (sel_q)
        DIV_AVG: avg_q   <= quot[SAMPLE_W-1:0];
        DIV_MAV: mav_q   <= quot[SAMPLE_W-1:0];
        default: wlres_q <= quot[SAMPLE_W-1:0];
      endcase
    end
    if (cmd_i.emit) begin
      m_data_q <= OUT_W'({tn_q, wlres_q, zc_q, mav_q, cmd_i.ch});
      m_last_q <= (cmd_i.ch == CH_W'(CHANNELS - 1));
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_AVG: div_in = sum_q + HALF;
      DIV_MAV: div_in = abs_q + HALF;
      default: div_in = wl_q + HALF;
    endcase
  end

  emgfe_div #(
    .WINDOW_LEN(WINDOW_LEN),
    .ACC_W     (ACC_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_in),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  assign status_o.trigger  = (wr_next == win_end_q);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !m_valid_q || out_ready_i;

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_data_q;
  assign out_last_o  = m_last_q;

endmodule
`default_nettype wire

>>> src/emgfe_ctrl.sv
// Controller state machine sequencing the two passes, divisions and results.
// Depends on emgfe_pkg.
`default_nettype none
module emgfe_ctrl #(
  parameter int unsigned WINDOW_LEN = emgfe_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire emgfe_pkg::dp_status_t status_i,
  output emgfe_pkg::dp_cmd_t         cmd_o
);
  import emgfe_pkg::*;

  localparam logic [KCNT_W-1:0] LEN = KCNT_W'(WINDOW_LEN);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SUM      = 10'b0000000010,
    S_AVG_GO   = 10'b0000000100,
    S_AVG_WAIT = 10'b0000001000,
    S_DEV      = 10'b0000010000,
    S_MAV_GO   = 10'b0000100000,
    S_MAV_WAIT = 10'b0001000000,
    S_WL_GO    = 10'b0010000000,
    S_WL_WAIT  = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [KCNT_W-1:0] cnt_q, cnt_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.wr       = accept;
    cmd_o.rd_k     = cnt_q;
    cmd_o.ch       = ch_q;
    cmd_o.div_sel  = DIV_AVG;
    unique case (state_q) inside
      S_IDLE: begin
        if (accept && status_i.trigger) begin
          state_d = S_SUM;
          cnt_d   = '0;
          ch_d    = '0;
        end
      end
      S_SUM, S_DEV: begin
        cmd_o.dev_pass = (state_q == S_DEV);
        cmd_o.clr      = (cnt_q == '0);
        cmd_o.rd_en    = (cnt_q < LEN);
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LEN) begin
          cnt_d   = '0;
          state_d = (state_q == S_SUM) ? S_AVG_GO : S_MAV_GO;
        end
      end
      S_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (status_i.div_done) state_d = S_DEV;
      end
      S_MAV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MAV;
        state_d         = S_MAV_WAIT;
      end
      S_MAV_WAIT: begin
        if (status_i.div_done) state_d = S_WL_GO;
      end
      S_WL_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_WL;
        state_d         = S_WL_WAIT;
      end
      S_WL_WAIT: begin
        cmd_o.div_sel = DIV_WL;
        if (status_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            cnt_d   = '0;
            state_d = S_SUM;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
    end
  end

endmodule
`default_nettype wire

>>> verif/tb_emg_window_feature_extractor_unit.sv
// Self-checking testbench for emg_window_feature_extractor_unit: streams sample
// sets through the ring and checks each per-channel feature request against an
// in-bench window analyser. Depends on emgfe_pkg and the unit under test.
`default_nettype none
module tb_emg_window_feature_extractor_unit;
  import emgfe_pkg::*;

  localparam int unsigned WIN = WINDOW_LEN_DEF;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [11:0]     mav;
    logic [5:0]      zc;
    logic [11:0]     wl;
    logic [5:0]      turns;
    logic            last;
  } features_t;

  logic                clk_i;
  logic                rst_ni;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                m_axis_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  emg_window_feature_extractor_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the block's ring, pointers and step register.
  logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH][CHANNELS];
  int unsigned         wr_ptr;
  int unsigned         win_first;
  int unsigned         win_stop;
  int unsigned         step_reg;

  features_t           pending_features [$];
  int                  mismatches;
  int                  snd_idle_pct;
  int                  rcv_stall_pct;
  bit                  hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit, taken well above the slowest correct run.
  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

  // Analyses one channel of the current window exactly as the hardware should:
  // centre on the rounded mean, then accumulate deviation, length, crossings
  // and slope turns over neighbours inside the window only.
  function automatic features_t measure_channel(int unsigned ch);
    features_t   f;
    int          d [WIN];
    int unsigned sum;
    int unsigned avg;
    int unsigned abs_sum;
    int unsigned wl_sum;
    int unsigned zc;
    int unsigned tn;
    int          s;
    int          s2;
    sum = 0; abs_sum = 0; wl_sum = 0; zc = 0; tn = 0;
    for (int k = 0; k < WIN; k++) begin
      d[k] = ring_copy[(win_first + k) % RING_DEPTH][ch];
      sum += d[k];
    end
    avg = (sum + WIN / 2) / WIN;
    for (int k = 0; k < WIN; k++) begin
      d[k] = d[k] - int'(avg);
      abs_sum += (d[k] < 0) ? -d[k] : d[k];
    end
    for (int k = 0; k + 1 < WIN; k++) begin
      s = d[k+1] - d[k];
      if ((d[k] < 0 && d[k+1] > 0) || (d[k] > 0 && d[k+1] < 0)) zc++;
      wl_sum += (s < 0) ? -s : s;
      if (k + 2 < WIN) begin
        s2 = d[k+2] - d[k+1];
        if ((s < 0 && s2 > 0) || (s > 0 && s2 < 0)) tn++;
      end
    end
    f.ch    = ch[CH_W-1:0];
    f.mav   = 12'((abs_sum + WIN / 2) / WIN);
    f.zc    = 6'(zc);
    f.wl    = 12'((wl_sum + WIN / 2) / WIN);
    f.turns = 6'(tn);
    f.last  = (ch == CHANNELS - 1);
    return f;
  endfunction

  // Stores one accepted sample set and queues the four feature requests when
  // it completes a window; the window then moves on by the step.
  task automatic store_sample_set(logic [IN_W-1:0] set);
    int unsigned step;
    for (int c = 0; c < CHANNELS; c++) ring_copy[wr_ptr][c] = set[c*SAMPLE_W +: SAMPLE_W];
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    if (wr_ptr == win_stop) begin
      step = step_reg % RING_DEPTH;
      win_stop = (win_stop + step) % RING_DEPTH;
      for (int c = 0; c < CHANNELS; c++) pending_features.push_back(measure_channel(c));
      win_first = (win_first + step) % RING_DEPTH;
    end
  endtask

  // Result side: compare each accepted request with the oldest expectation.
  always @(posedge clk_i) begin
    features_t got;
    features_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[13:2], m_axis_tdata[19:14],
             m_axis_tdata[31:20], m_axis_tdata[37:32], m_axis_tlast};
      if (pending_features.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result request: %p", got);
      end else begin
        want = pending_features.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver: random stalls per phase, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready = 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Register write: setup cycle, then access cycle; the shadow step follows
  // at the edge where the block takes it.
  task automatic write_step(int unsigned value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = REG_WINDOW_STEP; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    step_reg = value & 7'h7F;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Offers one sample set and returns once the block has accepted it.
  task automatic offer_sample_set(logic [IN_W-1:0] set);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = set;
    do @(posedge clk_i); while (!s_axis_tready);
    store_sample_set(set);
  endtask

  // Sender pause until every expected request has arrived, then some slack so
  // that a window still being analysed can finish before the next write.
  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_features.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Random sample sets shaped by a mode that is drawn anew every 12 items: full
  // range, rail-to-rail alternation (most crossings and turns), small noise
  // around mid-scale, and a flat signal.
  function automatic logic [IN_W-1:0] random_sample_set(int mode, int n);
    logic [IN_W-1:0] set;
    logic [11:0]     v;
    for (int c = 0; c < CHANNELS; c++) begin
      case (mode)
        0: begin
          v = 12'($urandom);
        end
        1: begin
          v = (n % 2) ? 12'hFFF - 12'($urandom_range(3)) : 12'($urandom_range(3));
        end
        2: begin
          v = 12'(2048 + $urandom_range(16) - 8);
        end
        default: begin
          v = 12'(1000 * c + 7);
        end
      endcase
      set[c*SAMPLE_W +: SAMPLE_W] = v;
    end
    return set;
  endfunction

  task automatic run_random_sets(int count);
    int mode;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 12 == 0) mode = $urandom_range(9) < 5 ? 0 : $urandom_range(3);
      offer_sample_set(random_sample_set(mode, n));
    end
  endtask

  // Directed sample sets: rails, bit patterns and single bits on each channel.
  logic [IN_W-1:0] directed_sets [] = '{
    {12'h000, 12'h000, 12'h000, 12'h000},
    {12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
    {12'h000, 12'hFFF, 12'h000, 12'hFFF},
    {12'hFFF, 12'h000, 12'hFFF, 12'h000},
    {12'hAAA, 12'h555, 12'hAAA, 12'h555},
    {12'h555, 12'hAAA, 12'h555, 12'hAAA},
    {12'h001, 12'h002, 12'h004, 12'h008},
    {12'h010, 12'h020, 12'h040, 12'h080},
    {12'h100, 12'h200, 12'h400, 12'h800},
    {12'h800, 12'h800, 12'h800, 12'h800},
    {12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF},
    {12'h801, 12'h7FE, 12'h801, 12'h7FE},
    {12'hFFE, 12'h001, 12'hFFE, 12'h001},
    {12'h000, 12'hFFF, 12'h000, 12'hFFF},
    {12'hFFF, 12'h000, 12'hFFF, 12'h000},
    {12'h123, 12'h456, 12'h789, 12'hABC},
    {12'hFED, 12'hCBA, 12'h987, 12'h654},
    {12'h800, 12'h7FF, 12'h800, 12'h7FF},
    {12'h000, 12'h000, 12'hFFF, 12'hFFF},
    {12'hFFF, 12'hFFF, 12'h000, 12'h000},
    {12'h3C3, 12'hC3C, 12'h3C3, 12'hC3C},
    {12'h000, 12'h000, 12'h000, 12'h000},
    {12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
    {12'h800, 12'h800, 12'h800, 12'h800},
    {12'h801, 12'h801, 12'h801, 12'h801}
  };

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_off_req  = 1'b0;
    wr_ptr        = 0;
    win_first     = 0;
    win_stop      = WIN % RING_DEPTH;
    step_reg      = STEP_RESET;
    foreach (ring_copy[i, c]) ring_copy[i][c] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset step, no idling: directed sets, then random fill to two windows.
    foreach (directed_sets[i]) offer_sample_set(directed_sets[i]);
    run_random_sets(75);
    wait_until_drained();

    // Smallest step; sender idles. No set here reaches the window end left by the last step.
    write_step(1);
    snd_idle_pct = 47;
    run_random_sets(40);
    wait_until_drained();

    // A step of a whole ring wraps to zero: one window per revolution.
    write_step(64);
    snd_idle_pct = 0; rcv_stall_pct = 47;
    run_random_sets(80);
    wait_until_drained();

    // Largest register value, reduced modulo the ring depth; both sides idle.
    write_step(127);
    snd_idle_pct = 18; rcv_stall_pct = 18;
    run_random_sets(70);
    wait_until_drained();

    // Short step with a long receiver hold-off, so the output backs up and
    // the input stalls while the sender keeps offering.
    write_step(13);
    snd_idle_pct = 0; rcv_stall_pct = 0;
    hold_off_req = 1'b1;
    run_random_sets(90);
    wait_until_drained();

    write_step(33);
    snd_idle_pct = 18; rcv_stall_pct = 47;
    run_random_sets(60);
    wait_until_drained();

    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_features.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/emgfe_pkg.sv
src/emgfe_div.sv
src/emgfe_datapath.sv
src/emgfe_ctrl.sv
src/emg_window_feature_extractor_unit.sv
verif/tb_emg_window_feature_extractor_unit.sv
